@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge and disabled during reset.
`define STFLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define STFLS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STFLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/stfls_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared widths, function codes and item types of the sorted table
// first/last occurrence search block.
// ----------------------------------------------------------------------------
`default_nettype none

package stfls_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned POS_W           = 10;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned CNT_W           = 11;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] first_index;
    logic [POS_W-1:0] last_index;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write one table entry
    logic start;    // capture the key and set up both searches
    logic run;      // advance the interleaved searches
    logic capture;  // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;     // both searches finished, no read outstanding
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/sorted_table_first_last_search.sv @@
// ----------------------------------------------------------------------------
// Sorted table first/last occurrence search
// Table of signed entries loaded in ascending order, searched for the lowest
// and the highest index holding a key.
// ----------------------------------------------------------------------------
// A load item writes one entry and yields no result. A query item runs two
// binary searches over the first entries_in_use entries; each probe is a
// registered memory read followed by a compare, and the two searches take
// turns on the one read port. One item is worked on at a time; a finished
// result waits in the output register while the next item is taken. Entries
// must be loaded before a search reaches them.
`default_nettype none

module sorted_table_first_last_search #(
  parameter int unsigned TABLE_DEPTH = stfls_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire stfls_pkg::in_item_t         in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output stfls_pkg::out_item_t             out_item_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [stfls_pkg::CNT_W-1:0] cfg_data_i
);
  import stfls_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  stfls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_item_i.func),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  stfls_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

@@ rtl/stfls_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted table search controller
// Input and output handshakes and sequencing of the datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module stfls_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_func_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output stfls_pkg::ctrl_cmd_t      cmd_o,
  input  wire stfls_pkg::dp_stat_t  stat_i
);
  import stfls_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o.load    = accept && (in_func_i == FUNC_LOAD);
    cmd_o.start   = accept && (in_func_i == FUNC_QUERY);
    cmd_o.run     = (state_q == ST_SEARCH);
    // A finished result waits here while the previous one is still stalled.
    cmd_o.capture = (state_q == ST_SEARCH) && stat_i.done && (!out_valid_q || !out_stall_i);

    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (cmd_o.capture) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/stfls_dpath.sv @@
// ----------------------------------------------------------------------------
// Sorted table search datapath
// Table memory, count register and two interleaved binary searches that
// share the single read port of the memory.
// ----------------------------------------------------------------------------
`default_nettype none

module stfls_dpath #(
  parameter int unsigned TABLE_DEPTH = stfls_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire stfls_pkg::ctrl_cmd_t      cmd_i,
  output stfls_pkg::dp_stat_t            stat_o,
  input  wire stfls_pkg::in_item_t       in_item_i,
  input  wire logic                      cfg_valid_i,
  input  wire logic [stfls_pkg::CNT_W-1:0] cfg_data_i,
  output stfls_pkg::out_item_t           out_item_o
);
  import stfls_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);

  // Side 0 finds the lowest match, side 1 the highest.
  localparam int unsigned SIDES = 2;

  logic signed [VAL_W-1:0] mem_q [TABLE_DEPTH];
  logic signed [VAL_W-1:0] rdata_q;
  logic signed [VAL_W-1:0] key_q;
  logic [CNT_W-1:0]        count_q;

  // Each side keeps a half-open range [lo, end).
  logic [CW-1:0]    lo_q   [SIDES];
  logic [CW-1:0]    end_q  [SIDES];
  logic [CW-1:0]    mid_q  [SIDES];
  logic [POS_W-1:0] hit_q  [SIDES];
  logic [SIDES-1:0] hitv_q;
  logic [SIDES-1:0] pend_q;
  logic             turn_q;

  logic [CW:0]      sum_c  [SIDES];
  logic [CW-1:0]    mid_c  [SIDES];
  logic [CW-1:0]    count_sat;
  logic [IDX_W-1:0] raddr;
  logic             issue;
  logic             wr_en;
  logic             probe_eq;
  logic             probe_lt;
  out_item_t        out_q;

  always_comb begin
    for (int s = 0; s < SIDES; s++) begin
      sum_c[s] = {1'b0, lo_q[s]} + {1'b0, end_q[s]} - {{CW{1'b0}}, 1'b1};
      mid_c[s] = sum_c[s][CW:1];
    end
  end

  assign count_sat = (32'(count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);
  assign issue     = cmd_i.run && (lo_q[turn_q] < end_q[turn_q]);
  assign raddr     = IDX_W'(mid_c[turn_q]);
  assign wr_en     = cmd_i.load && (32'(in_item_i.position) < 32'(TABLE_DEPTH));
  assign probe_eq  = (rdata_q == key_q);
  assign probe_lt  = (rdata_q < key_q);

  assign stat_o.done = (pend_q == '0) && (lo_q[0] >= end_q[0]) && (lo_q[1] >= end_q[1]);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[IDX_W'(in_item_i.position)] <= in_item_i.value;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SIDES; s++) begin
        lo_q[s]  <= '0;
        end_q[s] <= '0;
        mid_q[s] <= '0;
        hit_q[s] <= '0;
      end
      hitv_q <= '0;
      pend_q <= '0;
      turn_q <= 1'b0;
      key_q  <= '0;
    end else if (cmd_i.start) begin
      for (int s = 0; s < SIDES; s++) begin
        lo_q[s]  <= '0;
        end_q[s] <= count_sat;
        hit_q[s] <= '0;
      end
      hitv_q <= '0;
      pend_q <= '0;
      turn_q <= 1'b0;
      key_q  <= in_item_i.value;
    end else if (cmd_i.run) begin
      turn_q <= ~turn_q;
      // The read data belongs to whichever side has a probe outstanding.
      for (int s = 0; s < SIDES; s++) begin
        if (pend_q[s]) begin
          pend_q[s] <= 1'b0;
          if (probe_eq) begin
            hit_q[s]  <= POS_W'(mid_q[s]);
            hitv_q[s] <= 1'b1;
            if (s == 0) begin
              end_q[s] <= mid_q[s];
            end else begin
              lo_q[s] <= mid_q[s] + 1'b1;
            end
          end else if (probe_lt) begin
            lo_q[s] <= mid_q[s] + 1'b1;
          end else begin
            end_q[s] <= mid_q[s];
          end
        end
      end
      if (issue) begin
        pend_q[turn_q] <= 1'b1;
        mid_q[turn_q]  <= mid_c[turn_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      out_q.found       <= hitv_q[0] && hitv_q[1];
      out_q.first_index <= (hitv_q[0] && hitv_q[1]) ? hit_q[0] : '0;
      out_q.last_index  <= (hitv_q[0] && hitv_q[1]) ? hit_q[1] : '0;
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

@@ rtl/stfls_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted table search checker
// Port-level assertions on the handshakes and the result items.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stfls_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_stall_o,
  input  wire stfls_pkg::in_item_t         in_item_i,
  input  wire logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  input  wire stfls_pkg::out_item_t        out_item_o
);
  import stfls_pkg::*;

  logic out_wait;
  logic out_miss;
  logic out_hit;
  logic idx_zero;
  logic idx_order;
  logic query_take;

  assign out_wait   = out_valid_o && out_stall_i;
  assign out_miss   = out_valid_o && !out_item_o.found;
  assign out_hit    = out_valid_o && out_item_o.found;
  assign idx_zero   = (out_item_o.first_index == '0) && (out_item_o.last_index == '0);
  assign idx_order  = (out_item_o.first_index <= out_item_o.last_index);
  assign query_take = in_valid_i && !in_stall_o && (in_item_i.func == FUNC_QUERY);

  `STFLS_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o, "result dropped while stalled")
  `STFLS_ASSERT_NEXT(a_out_stable, out_wait, $stable(out_item_o), "stalled result changed")
  `STFLS_ASSERT_IMPL(a_miss_zero, out_miss, idx_zero, "miss with nonzero index")
  `STFLS_ASSERT_IMPL(a_hit_order, out_hit, idx_order, "first index above last index")
  `STFLS_ASSERT_NEXT(a_query_busy, query_take, in_stall_o, "query item did not start a search")

endmodule

bind sorted_table_first_last_search stfls_checker u_stfls_checker (.*);

`default_nettype wire
